>>> design/rlc_umd_pkg.sv
// Shared types and constants of the RLC UMD header parser.
// Used by the parser front, the queue, the result back end and the top level.
package rlc_umd_pkg;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int SUM_W = 16;

  localparam logic REG_SN_MODE = 1'b0;
  localparam logic REG_MAX_LI  = 1'b1;

  localparam logic KIND_LI      = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [10:0] MAX_LI_RESET = 11'h7FF;

  typedef logic [10:0] li_value_t;
  typedef logic [13:0] offset_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_PARSE    = 2'd1,
    ST_INVALID  = 2'd2,
    ST_RESERVED = 2'd3
  } status_t;

  typedef struct packed {
    logic      has_li;
    li_value_t li_value;
    logic [4:0] li_index;
    logic      has_sum;
    status_t   status;
    logic [1:0] framing;
    logic [9:0] seq;
    logic [5:0] count;
    offset_t   offset;
    offset_t   dlen;
  } entry_t;

  typedef struct packed {
    logic      kind;
    li_value_t li_value;
    logic [4:0] li_index;
    status_t   status;
    logic [1:0] framing;
    logic [9:0] seq;
    logic [5:0] count;
    offset_t   offset;
    offset_t   dlen;
    logic      last;
  } result_t;

  function automatic result_t li_result(entry_t e);
    result_t r;
    r = '0;
    r.kind = KIND_LI;
    r.li_value = e.li_value;
    r.li_index = e.li_index;
    r.status = ST_OK;
    r.last = !e.has_sum;
    return r;
  endfunction

  function automatic result_t sum_result(entry_t e);
    result_t r;
    r = '0;
    r.kind = KIND_SUMMARY;
    r.status = e.status;
    r.framing = e.framing;
    r.seq = e.seq;
    r.count = e.count;
    r.offset = e.offset;
    r.dlen = e.dlen;
    r.last = 1'b1;
    return r;
  endfunction

endpackage

>>> design/rlc_umd_in_if.sv
// Byte channel into the RLC UMD header parser: valid/ready plus one PDU byte.
// Depends on nothing; LENGTH_BITS sets the width of the PDU length.
interface rlc_umd_in_if #(
  parameter int LENGTH_BITS = 14
);
  logic                   valid;
  logic                   ready;
  logic [7:0]             data_byte;
  logic [LENGTH_BITS-1:0] pdu_len;
  logic                   first_byte;

  modport source (output valid, data_byte, pdu_len, first_byte, input ready);
  modport sink (input valid, data_byte, pdu_len, first_byte, output ready);
endinterface

>>> design/rlc_umd_out_if.sv
// Result channel of the RLC UMD header parser: LI entries and header summaries.
// Depends on nothing.
interface rlc_umd_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [10:0] li_value;
  logic [4:0]  li_index;
  logic [1:0]  status;
  logic [1:0]  framing_info;
  logic [9:0]  seq_number;
  logic [5:0]  li_count;
  logic [13:0] data_offset;
  logic [13:0] payload_len;
  logic        last_of_run;

  modport source (output valid, result_kind, li_value, li_index, status, framing_info,
                  seq_number, li_count, data_offset, payload_len, last_of_run, input ready);
  modport sink (input valid, result_kind, li_value, li_index, status, framing_info,
                seq_number, li_count, data_offset, payload_len, last_of_run, output ready);
endinterface

>>> design/rlc_umd_header_parser_core.sv
// RLC UMD header parser: takes one PDU byte per clock and returns LI entries and a header
// summary. A byte is accepted every cycle while the four-entry result queue has room; results
// leave one per cycle while the receiver is ready, so a byte that completes the list (LI plus
// summary) yields two results, and a long backpressure on results fills the queue and drops
// ready. The first result of a byte is registered in the queue, then in the output register.
// Registers: sn_mode at 0x0, max_li_value at 0x4; write them only while the parser is idle.
module rlc_umd_header_parser_core #(
  parameter int MAX_INDICATORS = 32,
  parameter int LENGTH_BITS = 14
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rlc_umd_pkg::ADDR_W-1:0]      paddr,
  input  logic [rlc_umd_pkg::DATA_W-1:0]      pwdata,
  output logic [rlc_umd_pkg::DATA_W-1:0]      prdata,
  output logic                                pready,
  rlc_umd_in_if.sink                          pdu,
  rlc_umd_out_if.source                       result
);

  logic                sn_mode;
  logic [10:0]         max_li_value;
  logic                q_push, q_pop, q_empty, q_full;
  rlc_umd_pkg::entry_t q_entry, q_head;
  logic                wr_en;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      sn_mode <= 1'b0;
      max_li_value <= rlc_umd_pkg::MAX_LI_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        rlc_umd_pkg::REG_SN_MODE: sn_mode <= pwdata[0];
        rlc_umd_pkg::REG_MAX_LI:  max_li_value <= pwdata[10:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      rlc_umd_pkg::REG_SN_MODE: prdata = {31'b0, sn_mode};
      rlc_umd_pkg::REG_MAX_LI:  prdata = {21'b0, max_li_value};
      default: prdata = '0;
    endcase
  end

  rlc_umd_front #(
    .MAX_INDICATORS(MAX_INDICATORS),
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .pdu(pdu),
    .sn_mode(sn_mode),
    .max_li_value(max_li_value),
    .q_full(q_full),
    .q_push(q_push),
    .q_entry(q_entry)
  );

  rlc_umd_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(q_push),
    .push_entry(q_entry),
    .pop(q_pop),
    .head(q_head),
    .empty(q_empty),
    .full(q_full)
  );

  rlc_umd_back u_back (
    .clk(clk),
    .rst(rst),
    .head(q_head),
    .q_empty(q_empty),
    .q_pop(q_pop),
    .result(result)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("result entry pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("result entry popped from an empty queue");

  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.result_kind == rlc_umd_pkg::KIND_SUMMARY |-> result.last_of_run)
    else $error("header summary not marked last of its run");

  a_li_then_summary: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.ready && result.result_kind == rlc_umd_pkg::KIND_LI &&
    !result.last_of_run |=> result.valid && result.result_kind == rlc_umd_pkg::KIND_SUMMARY)
    else $error("summary does not follow an LI that is not last of its run");

endmodule

>>> design/rlc_umd_front.sv
// Parser front: accepts PDU bytes, decodes the fixed header and the LI list,
// and pushes result entries into the queue. Depends on rlc_umd_pkg and rlc_umd_in_if.
module rlc_umd_front #(
  parameter int MAX_INDICATORS = 32,
  parameter int LENGTH_BITS = 14
) (
  input  logic                   clk,
  input  logic                   rst,
  rlc_umd_in_if.sink             pdu,
  input  logic                   sn_mode,
  input  logic [10:0]            max_li_value,
  input  logic                   q_full,
  output logic                   q_push,
  output rlc_umd_pkg::entry_t    q_entry
);

  localparam int CNT_W = $clog2(MAX_INDICATORS + 1);
  localparam int LB = LENGTH_BITS;
  localparam int SW = rlc_umd_pkg::SUM_W;

  typedef enum logic [2:0] {
    PH_IDLE, PH_SN10, PH_LI_A, PH_LI_B, PH_LI_C, PH_DONE
  } phase_t;

  phase_t            phase, phase_next;
  logic [LB-1:0]     pos, pos_next;
  logic [LB-1:0]     len, len_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic [SW-1:0]     sum, sum_next;
  logic [10:0]       part, part_next;
  logic              ext, ext_next;
  logic [1:0]        fi, fi_next;
  logic [9:0]        sn, sn_next;

  logic              acc;
  logic [7:0]        b;
  logic [10:0]       li_val;
  logic [LB:0]       step_pos;
  logic [LB:0]       end_pos;
  logic [LB-1:0]     rem;
  logic [SW:0]       sum_wide;
  logic              li_bad;
  logic              has_li, has_sum;
  rlc_umd_pkg::status_t sum_st;
  logic [LB:0]       sum_off, sum_len;

  assign acc = pdu.valid && pdu.ready;
  assign pdu.ready = !q_full;
  assign b = pdu.data_byte;

  always_comb begin
    phase_next = phase;
    pos_next = pos;
    len_next = len;
    cnt_next = cnt;
    sum_next = sum;
    part_next = part;
    ext_next = ext;
    fi_next = fi;
    sn_next = sn;
    has_li = 1'b0;
    has_sum = 1'b0;
    sum_st = rlc_umd_pkg::ST_OK;
    sum_off = '0;
    sum_len = '0;
    li_val = (phase == PH_LI_B) ? (part | {7'b0, b[7:4]}) : (part | {3'b0, b});
    step_pos = {1'b0, pos} + ((phase == PH_LI_B) ? (LB+1)'(1) : (LB+1)'(2));
    end_pos = {1'b0, pos} + (LB+1)'(1);
    rem = len - end_pos[LB-1:0];
    li_bad = (cnt >= CNT_W'(MAX_INDICATORS)) || (li_val == '0) || (li_val > max_li_value);
    sum_wide = {1'b0, sum} + (SW+1)'(li_val);
    if (acc) begin
      if (pdu.first_byte) begin
        pos_next = LB'(1);
        len_next = pdu.pdu_len;
        cnt_next = '0;
        sum_next = '0;
        part_next = '0;
        ext_next = 1'b0;
        fi_next = '0;
        sn_next = '0;
        phase_next = PH_IDLE;
        if (pdu.pdu_len == '0) begin
          has_sum = 1'b1;
          sum_st = rlc_umd_pkg::ST_PARSE;
        end else if (!sn_mode) begin
          fi_next = b[7:6];
          ext_next = b[5];
          sn_next = {5'b0, b[4:0]};
          if (!b[5]) begin
            has_sum = 1'b1;
            sum_off = (LB+1)'(1);
            sum_len = {1'b0, pdu.pdu_len} - (LB+1)'(1);
          end else if (pdu.pdu_len <= LB'(2)) begin
            has_sum = 1'b1;
            sum_st = rlc_umd_pkg::ST_PARSE;
          end else begin
            phase_next = PH_LI_A;
          end
        end else if (pdu.pdu_len < LB'(2)) begin
          has_sum = 1'b1;
          sum_st = rlc_umd_pkg::ST_PARSE;
        end else if (b[7:5] != 3'b000) begin
          has_sum = 1'b1;
          sum_st = rlc_umd_pkg::ST_RESERVED;
        end else begin
          fi_next = b[4:3];
          ext_next = b[2];
          sn_next = {b[1:0], 8'h00};
          phase_next = PH_SN10;
        end
      end else if (phase != PH_IDLE && phase != PH_DONE) begin
        pos_next = pos + LB'(1);
        unique case (phase)
          PH_SN10: begin
            sn_next = {sn[9:8], b};
            if (!ext) begin
              has_sum = 1'b1;
              sum_off = (LB+1)'(2);
              sum_len = {1'b0, len} - (LB+1)'(2);
            end else if (len <= LB'(3)) begin
              has_sum = 1'b1;
              sum_st = rlc_umd_pkg::ST_PARSE;
            end else begin
              phase_next = PH_LI_A;
            end
          end
          PH_LI_A: begin
            ext_next = b[7];
            part_next = {b[6:0], 4'h0};
            phase_next = PH_LI_B;
          end
          PH_LI_B, PH_LI_C: begin
            phase_next = (phase == PH_LI_B) ? PH_LI_C : PH_LI_A;
            if (phase == PH_LI_B) begin
              ext_next = b[3];
              part_next = {b[2:0], 8'h00};
            end
            if (li_bad) begin
              has_sum = 1'b1;
              sum_st = rlc_umd_pkg::ST_INVALID;
            end else begin
              has_li = 1'b1;
              cnt_next = cnt + CNT_W'(1);
              sum_next = sum_wide[SW] ? '1 : sum_wide[SW-1:0];
              if (ext) begin
                if (step_pos >= {1'b0, len}) begin
                  has_sum = 1'b1;
                  sum_st = rlc_umd_pkg::ST_PARSE;
                end
              end else if (end_pos >= {1'b0, len} || sum_next >= SW'(rem)) begin
                has_sum = 1'b1;
                sum_st = rlc_umd_pkg::ST_INVALID;
              end else begin
                has_sum = 1'b1;
                sum_off = end_pos;
                sum_len = (LB+1)'(rem);
              end
            end
          end
          default: begin
          end
        endcase
      end
      if (has_sum) begin
        phase_next = PH_DONE;
      end
    end
  end

  always_comb begin
    q_entry = '0;
    q_entry.has_li = has_li;
    q_entry.li_value = li_val;
    q_entry.li_index = 5'(cnt);
    q_entry.has_sum = has_sum;
    q_entry.status = sum_st;
    q_entry.framing = fi_next;
    q_entry.seq = sn_next;
    q_entry.count = 6'(cnt_next);
    q_entry.offset = rlc_umd_pkg::offset_t'(sum_off);
    q_entry.dlen = rlc_umd_pkg::offset_t'(sum_len);
  end

  assign q_push = acc && (has_li || has_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      pos <= '0;
      len <= '0;
      cnt <= '0;
      sum <= '0;
      part <= '0;
      ext <= 1'b0;
      fi <= '0;
      sn <= '0;
    end else begin
      phase <= phase_next;
      pos <= pos_next;
      len <= len_next;
      cnt <= cnt_next;
      sum <= sum_next;
      part <= part_next;
      ext <= ext_next;
      fi <= fi_next;
      sn <= sn_next;
    end
  end

endmodule

>>> design/rlc_umd_queue.sv
// Short queue of result entries between the parser front and the result back end.
// Depends on rlc_umd_pkg.
module rlc_umd_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  rlc_umd_pkg::entry_t push_entry,
  input  logic                pop,
  output rlc_umd_pkg::entry_t head,
  output logic                empty,
  output logic                full
);

  localparam int DEPTH = rlc_umd_pkg::QUEUE_DEPTH;
  localparam int PW = $clog2(DEPTH);

  rlc_umd_pkg::entry_t mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   count;

  assign empty = (count == '0);
  assign full = (count == (PW+1)'(DEPTH));
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      unique case ({push, pop})
        2'b10: count <= count + (PW+1)'(1);
        2'b01: count <= count - (PW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

>>> design/rlc_umd_back.sv
// Result back end: pops queue entries and presents them as one or two results
// through an output register. Depends on rlc_umd_pkg and rlc_umd_out_if.
module rlc_umd_back (
  input  logic                clk,
  input  logic                rst,
  input  rlc_umd_pkg::entry_t head,
  input  logic                q_empty,
  output logic                q_pop,
  rlc_umd_out_if.source       result
);

  rlc_umd_pkg::entry_t  held;
  rlc_umd_pkg::result_t res;
  logic                 res_valid;
  logic                 pend_sum;
  logic                 load;

  assign load = !res_valid || result.ready;
  assign q_pop = load && !pend_sum && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      pend_sum <= 1'b0;
    end else if (load) begin
      if (pend_sum) begin
        res <= rlc_umd_pkg::sum_result(held);
        res_valid <= 1'b1;
        pend_sum <= 1'b0;
      end else if (!q_empty) begin
        held <= head;
        res_valid <= 1'b1;
        if (head.has_li) begin
          res <= rlc_umd_pkg::li_result(head);
          pend_sum <= head.has_sum;
        end else begin
          res <= rlc_umd_pkg::sum_result(head);
        end
      end else begin
        res_valid <= 1'b0;
      end
    end
  end

  assign result.valid = res_valid;
  assign result.result_kind = res.kind;
  assign result.li_value = res.li_value;
  assign result.li_index = res.li_index;
  assign result.status = res.status;
  assign result.framing_info = res.framing;
  assign result.seq_number = res.seq;
  assign result.li_count = res.count;
  assign result.data_offset = res.offset;
  assign result.payload_len = res.dlen;
  assign result.last_of_run = res.last;

endmodule
